// File: rtl/u8d_pkg.sv
package u8d_pkg;

  // byte classes
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;
  localparam logic [7:0] ASCII_TOP  = 8'h80;

  // sequence lengths
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_1    = 3'd1;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

  // scalar value limits
  localparam logic [20:0] MIN_2BYTE = 21'h80;
  localparam logic [20:0] MIN_3BYTE = 21'h800;
  localparam logic [20:0] MIN_4BYTE = 21'h10000;
  localparam logic [20:0] CP_MAX    = 21'h10FFFF;
  localparam logic [20:0] SURR_LO   = 21'hD800;
  localparam logic [20:0] SURR_HI   = 21'hDFFF;

  localparam int HELD_DEPTH = 3;
  localparam int RUN_SLOTS  = 4;

  typedef struct packed {
    logic [20:0] acc;
    logic [2:0]  exp_len;
    logic [2:0]  cnt;
  } seq_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        valid_res;
    logic [7:0]  raw_byte;
    logic [2:0]  seq_length;
  } res_t;

  typedef struct packed {
    res_t [RUN_SLOTS-1:0] slot;
    logic [2:0]           count;
  } run_t;

  function automatic res_t mk_error(input logic [7:0] b);
    res_t r;
    r.code_point = '0;
    r.valid_res  = 1'b0;
    r.raw_byte   = b;
    r.seq_length = LEN_1;
    return r;
  endfunction

  function automatic res_t mk_point(input logic [20:0] cp, input logic [2:0] len);
    res_t r;
    r.code_point = cp;
    r.valid_res  = 1'b1;
    r.raw_byte   = '0;
    r.seq_length = len;
    return r;
  endfunction

endpackage

// File: rtl/u8d_channels.sv
interface u8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface u8d_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        valid_res;
  logic [7:0]  raw_byte;
  logic [2:0]  seq_length;
  logic        last_of_run;

  modport source (output valid, output code_point, output valid_res, output raw_byte,
                  output seq_length, output last_of_run, input ready);
  modport sink   (input valid, input code_point, input valid_res, input raw_byte,
                  input seq_length, input last_of_run, output ready);
endinterface

// File: rtl/u8d_step.sv
module u8d_step
  import u8d_pkg::*;
(
  input  seq_t                        cur,
  input  logic [HELD_DEPTH-1:0][7:0]  held,
  input  logic [7:0]                  data_byte,
  input  logic                        end_of_text,
  output seq_t                        nxt,
  output logic [HELD_DEPTH-1:0][7:0]  held_next,
  output run_t                        run
);

  logic [2:0]  k;
  logic        taken;
  logic [20:0] acc_n;
  logic [2:0]  cnt_n;
  logic        bad;

  always_comb begin
    nxt       = cur;
    held_next = held;
    run       = '0;
    k         = '0;
    taken     = 1'b0;
    acc_n     = {cur.acc[14:0], data_byte[5:0]};
    cnt_n     = cur.cnt + 3'd1;
    bad       = (cur.exp_len == LEN_2 && acc_n < MIN_2BYTE) ||
                (cur.exp_len == LEN_3 && acc_n < MIN_3BYTE) ||
                (cur.exp_len == LEN_4 && acc_n < MIN_4BYTE) ||
                (acc_n > CP_MAX) ||
                (acc_n >= SURR_LO && acc_n <= SURR_HI);

    // pending sequence: continue it or break it
    if (cur.exp_len != LEN_NONE) begin
      if ((data_byte & CONT_MASK) == CONT_TAG) begin
        taken = 1'b1;
        if (cnt_n >= cur.exp_len) begin
          if (bad) begin
            for (int i = 0; i < HELD_DEPTH; i++) begin
              if (3'(i) < cur.cnt) begin
                run.slot[k[1:0]] = mk_error(held[i]);
                k = k + 3'd1;
              end
            end
            run.slot[k[1:0]] = mk_error(data_byte);
            k = k + 3'd1;
          end else begin
            run.slot[k[1:0]] = mk_point(acc_n, cur.exp_len);
            k = k + 3'd1;
          end
          nxt = '0;
        end else begin
          nxt.acc = acc_n;
          nxt.cnt = cnt_n;
          held_next[cur.cnt[1:0]] = data_byte;
        end
      end else begin
        for (int i = 0; i < HELD_DEPTH; i++) begin
          if (3'(i) < cur.cnt) begin
            run.slot[k[1:0]] = mk_error(held[i]);
            k = k + 3'd1;
          end
        end
        nxt = '0;
      end
    end

    // byte not absorbed: decode it as a lead
    if (!taken) begin
      if (data_byte < ASCII_TOP) begin
        run.slot[k[1:0]] = mk_point({13'd0, data_byte}, LEN_1);
        k = k + 3'd1;
      end else if ((data_byte & LEAD2_MASK) == LEAD2_TAG) begin
        nxt.exp_len = LEN_2;
        nxt.acc     = {16'd0, data_byte[4:0]};
      end else if ((data_byte & LEAD3_MASK) == LEAD3_TAG) begin
        nxt.exp_len = LEN_3;
        nxt.acc     = {17'd0, data_byte[3:0]};
      end else if ((data_byte & LEAD4_MASK) == LEAD4_TAG) begin
        nxt.exp_len = LEN_4;
        nxt.acc     = {18'd0, data_byte[2:0]};
      end else begin
        run.slot[k[1:0]] = mk_error(data_byte);
        k = k + 3'd1;
      end
      if (nxt.exp_len != LEN_NONE) begin
        nxt.cnt      = 3'd1;
        held_next[0] = data_byte;
      end
    end

    // end of text flushes whatever is still pending
    if (end_of_text && nxt.exp_len != LEN_NONE) begin
      for (int i = 0; i < HELD_DEPTH; i++) begin
        if (3'(i) < nxt.cnt) begin
          run.slot[k[1:0]] = mk_error(held_next[i]);
          k = k + 3'd1;
        end
      end
      nxt = '0;
    end

    run.count = k;
  end

endmodule

// File: rtl/utf8_stream_decoder.sv
// channel   dir  beat payload
// text      in   data_byte[7:0], end_of_text
// points    out  code_point[20:0], valid_res, raw_byte[7:0], seq_length[2:0], last_of_run
//
// one byte per cycle when each byte yields at most one result and points is ready;
// a byte that yields n results holds the input while the result run drains
// a text beat reaches points through the input reg and then the run reg
// rst is synchronous: clears the pending sequence, input reg and run reg
// text stalls only while the run reg holds results other than the last one
// being taken; points stalls never lose decoder state
module utf8_stream_decoder
  import u8d_pkg::*;
(
  input logic      clk,
  input logic      rst,
  u8d_in_if.sink   text,
  u8d_out_if.source points
);

  // input register
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_eot;

  // decoder state
  seq_t                       seq;
  logic [HELD_DEPTH-1:0][7:0] held;

  // result run register, drained one beat at a time
  run_t       run;
  logic       run_valid;
  logic [1:0] ptr;

  // step outputs
  seq_t                       seq_next;
  logic [HELD_DEPTH-1:0][7:0] held_next;
  run_t                       run_next;

  logic last_slot;
  logic drain_done;
  logic advance;

  u8d_step u_step (
    .cur         (seq),
    .held        (held),
    .data_byte   (in_byte),
    .end_of_text (in_eot),
    .nxt         (seq_next),
    .held_next   (held_next),
    .run         (run_next)
  );

  // run reg frees when its final result is taken
  assign last_slot  = ({1'b0, ptr} + 3'd1) == run.count;
  assign drain_done = run_valid && points.ready && last_slot;
  assign advance    = in_full && (!run_valid || drain_done);
  assign text.ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full     <= 1'b0;
      run_valid   <= 1'b0;
      ptr         <= '0;
      seq         <= '0;
    end else begin
      // input register: load on accept, empty when its byte moves on
      if (text.valid && text.ready) begin
        in_full <= 1'b1;
        in_byte <= text.data_byte;
        in_eot  <= text.end_of_text;
      end else if (advance) begin
        in_full <= 1'b0;
      end

      // step the decoder and capture its results
      if (advance) begin
        seq  <= seq_next;
        held <= held_next;
        if (run_next.count != 3'd0) begin
          run       <= run_next;
          run_valid <= 1'b1;
          ptr       <= '0;
        end else if (drain_done) begin
          run_valid <= 1'b0;
        end
      end else if (run_valid && points.ready) begin
        if (last_slot) begin
          run_valid <= 1'b0;
        end else begin
          ptr <= ptr + 2'd1;
        end
      end
    end
  end

  assign points.valid       = run_valid;
  assign points.code_point  = run.slot[ptr].code_point;
  assign points.valid_res   = run.slot[ptr].valid_res;
  assign points.raw_byte    = run.slot[ptr].raw_byte;
  assign points.seq_length  = run.slot[ptr].seq_length;
  assign points.last_of_run = last_slot;

  // read pointer stays inside the run being drained
  a_ptr_in_run: assert property (@(posedge clk) disable iff (rst)
    run_valid |-> ({1'b0, ptr} < run.count))
    else $error("run pointer past end of run");

  // a pending sequence always has between one and length-1 bytes held
  a_seq_count: assert property (@(posedge clk) disable iff (rst)
    (seq.exp_len != LEN_NONE) |-> (seq.cnt != 3'd0 && seq.cnt < seq.exp_len))
    else $error("pending sequence count out of range");

  // end of text leaves nothing pending
  a_eot_flush: assert property (@(posedge clk) disable iff (rst)
    (advance && in_eot) |=> (seq.exp_len == LEN_NONE))
    else $error("sequence still pending after end of text");

  // an error beat carries one byte and no code point
  a_error_beat: assert property (@(posedge clk) disable iff (rst)
    (points.valid && !points.valid_res) |->
      (points.code_point == '0 && points.seq_length == LEN_1))
    else $error("malformed error beat");

  // reset empties the result side
  a_reset_idle: assert property (@(posedge clk) rst |=> !points.valid)
    else $error("results offered after reset");

endmodule
